// ===== hdl/lpc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_pkg
// Shared types, constants and helpers of the 3x3 local pattern code block.
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int NB_COUNT  = 8;
  localparam int PIX_W     = 8;
  localparam int FLAG_W    = 4;
  localparam int CODE_W    = 13;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 8;

  typedef enum logic [1:0] {
    MODE_LBP    = 2'd0,
    MODE_CS_LBP = 2'd1,
    MODE_LTP    = 2'd2,
    MODE_CS_LTP = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PATTERN_MODE = 2'd0,
    REG_PAD_MODE     = 2'd1,
    REG_THRESHOLD    = 2'd2
  } reg_idx_t;

  // Border flag bit positions.
  localparam int FLAG_LEFT   = 0;
  localparam int FLAG_RIGHT  = 1;
  localparam int FLAG_TOP    = 2;
  localparam int FLAG_BOTTOM = 3;

  typedef logic [8:0][PIX_W-1:0] window_t;
  typedef logic [NB_COUNT-1:0][1:0] trit_vec_t;

  typedef struct packed {
    mode_t            mode;
    logic             pad_zero;
    logic [PIX_W-1:0] threshold;
  } cfg_t;

  // Neighbor offsets, east first, running clockwise with y growing downward.
  localparam int OFF_X [NB_COUNT] = '{1, 1, 0, -1, -1, -1, 0, 1};
  localparam int OFF_Y [NB_COUNT] = '{0, 1, 1, 1, 0, -1, -1, -1};
  localparam logic [CODE_W-1:0] POW3 [NB_COUNT] =
    '{13'd1, 13'd3, 13'd9, 13'd27, 13'd81, 13'd243, 13'd729, 13'd2187};

  // Value of neighbor k after padding. An outside neighbor either reads as
  // zero or has its offending offsets clamped back onto the center row or
  // column of the window.
  function automatic logic [PIX_W-1:0] pad_pick(input window_t win,
                                                input logic [FLAG_W-1:0] flags,
                                                input logic pad_zero,
                                                input int k);
    int   dx;
    int   dy;
    int   idx;
    logic out_x;
    logic out_y;
    dx    = OFF_X[k];
    dy    = OFF_Y[k];
    out_x = ((dx < 0) && flags[FLAG_LEFT]) || ((dx > 0) && flags[FLAG_RIGHT]);
    out_y = ((dy < 0) && flags[FLAG_TOP]) || ((dy > 0) && flags[FLAG_BOTTOM]);
    if (out_x) dx = 0;
    if (out_y) dy = 0;
    idx = (dy + 1) * 3 + (dx + 1);
    if ((out_x || out_y) && pad_zero) begin
      return '0;
    end
    return win[idx[3:0]];
  endfunction

endpackage

// ===== hdl/lpc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_in_if / lpc_out_if
// Valid/ready channels carrying a 3x3 window in and a pattern code out.
// ----------------------------------------------------------------------------
interface lpc_in_if;
  logic                          valid;
  logic                          ready;
  logic [lpc_pkg::PIX_W-1:0]     pix_center;
  logic [lpc_pkg::PIX_W-1:0]     pix_east;
  logic [lpc_pkg::PIX_W-1:0]     pix_south_east;
  logic [lpc_pkg::PIX_W-1:0]     pix_south;
  logic [lpc_pkg::PIX_W-1:0]     pix_south_west;
  logic [lpc_pkg::PIX_W-1:0]     pix_west;
  logic [lpc_pkg::PIX_W-1:0]     pix_north_west;
  logic [lpc_pkg::PIX_W-1:0]     pix_north;
  logic [lpc_pkg::PIX_W-1:0]     pix_north_east;
  logic [lpc_pkg::FLAG_W-1:0]    border_flags;

  modport source (output valid, pix_center, pix_east, pix_south_east, pix_south,
                  pix_south_west, pix_west, pix_north_west, pix_north,
                  pix_north_east, border_flags, input ready);
  modport sink   (input valid, pix_center, pix_east, pix_south_east, pix_south,
                  pix_south_west, pix_west, pix_north_west, pix_north,
                  pix_north_east, border_flags, output ready);
endinterface

interface lpc_out_if;
  logic                          valid;
  logic                          ready;
  logic [lpc_pkg::CODE_W-1:0]    pattern_code;

  modport source (output valid, pattern_code, input ready);
  modport sink   (input valid, pattern_code, output ready);
endinterface

// ===== hdl/local_pattern_code_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_pattern_code_3x3
// Local binary / ternary pattern code of a 3x3 window with border padding.
// ----------------------------------------------------------------------------
//  Channel | Dir | Handshake     | Payload
//  in_ch   | in  | valid / ready | nine 8-bit pixels, 4-bit border flags
//  out_ch  | out | valid / ready | 13-bit pattern_code
//  cfg     | in  | cfg_write     | cfg_index (2 bits), cfg_data (8 bits)
//
// One window per clock unless the output is held. The eight compare lanes are
// registered, then the merge adder tree feeds the output register. Both stages
// advance whenever the next one is free, so a held output stalls the pipe only
// once both stages are full.
// Synchronous reset clears the stage valid bits and the cfg registers to zero.
// ----------------------------------------------------------------------------
module local_pattern_code_3x3 (
  input  logic                            clk,
  input  logic                            rst,
  lpc_in_if.sink                          in_ch,
  lpc_out_if.source                       out_ch,
  input  logic                            cfg_write,
  input  logic [lpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [lpc_pkg::CFG_DAT_W-1:0]   cfg_data
);

  lpc_pkg::cfg_t              cfg;
  lpc_pkg::window_t           win;
  lpc_pkg::trit_vec_t         lane_trits;
  lpc_pkg::trit_vec_t         s1_trits;
  logic                       s1_valid;
  logic                       s1_ternary;
  logic                       s1_advance;
  logic                       out_free;
  logic [lpc_pkg::CODE_W-1:0] merged;
  logic [lpc_pkg::CODE_W-1:0] code;
  logic                       out_valid;
  logic                       out_ternary;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{mode: lpc_pkg::MODE_LBP, pad_zero: 1'b0, threshold: '0};
    end else if (cfg_write) begin
      unique case (cfg_index)
        lpc_pkg::REG_PATTERN_MODE: cfg.mode      <= lpc_pkg::mode_t'(cfg_data[1:0]);
        lpc_pkg::REG_PAD_MODE:     cfg.pad_zero  <= cfg_data[0];
        lpc_pkg::REG_THRESHOLD:    cfg.threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  // Window in row-major order, center at index 4.
  assign win = {in_ch.pix_south_east, in_ch.pix_south, in_ch.pix_south_west,
                in_ch.pix_east, in_ch.pix_center, in_ch.pix_west,
                in_ch.pix_north_east, in_ch.pix_north, in_ch.pix_north_west};

  for (genvar k = 0; k < lpc_pkg::NB_COUNT; k++) begin : g_lane
    lpc_lane #(.K(k)) u_lane (
      .win   (win),
      .flags (in_ch.border_flags),
      .cfg   (cfg),
      .trit  (lane_trits[k])
    );
  end

  assign out_free    = !out_valid || out_ch.ready;
  assign s1_advance  = !s1_valid || out_free;
  assign in_ch.ready = s1_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_advance) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && in_ch.valid) begin
      s1_trits   <= lane_trits;
      s1_ternary <= cfg.mode[1];
    end
  end

  lpc_merge u_merge (
    .trits   (s1_trits),
    .ternary (s1_ternary),
    .code    (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid) begin
      code        <= merged;
      out_ternary <= s1_ternary;
    end
  end

  assign out_ch.valid        = out_valid;
  assign out_ch.pattern_code = code;

  // A full stage with a free output moves on in the next cycle.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_free |=> out_valid)
    else $error("stage one result did not reach the output register");

  // Input is refused only when both stages hold work and the output is held.
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (s1_valid && out_valid && !out_ch.ready))
    else $error("input stalled while the pipeline had room");

  // Binary codes stay within eight bits; ternary codes within 3^8 - 1.
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_ternary ? (code <= 13'd6560) : (code[12:8] == 5'd0)))
    else $error("pattern code out of range for its mode");

endmodule

// ===== hdl/lpc_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_lane
// One neighbor lane: pads its neighbor and the opposite one, then compares.
// ----------------------------------------------------------------------------
module lpc_lane #(
  parameter int K = 0
) (
  input  lpc_pkg::window_t              win,
  input  logic [lpc_pkg::FLAG_W-1:0]    flags,
  input  lpc_pkg::cfg_t                 cfg,
  output logic [1:0]                    trit
);

  localparam int OPP = (K + 4) % lpc_pkg::NB_COUNT;

  logic [lpc_pkg::PIX_W-1:0] nb;
  logic [lpc_pkg::PIX_W-1:0] opp;
  logic [lpc_pkg::PIX_W-1:0] center;
  logic [lpc_pkg::PIX_W-1:0] ref_pix;
  logic [lpc_pkg::PIX_W:0]   ref_hi;
  logic [lpc_pkg::PIX_W:0]   nb_plus_t;

  always_comb begin
    nb      = lpc_pkg::pad_pick(win, flags, cfg.pad_zero, K);
    opp     = lpc_pkg::pad_pick(win, flags, cfg.pad_zero, OPP);
    center  = win[4];
    ref_pix = (cfg.mode == lpc_pkg::MODE_CS_LTP) ? opp : center;
    // Compare in nine bits so c+T and c-T need no saturation:
    // n >= c-T is tested as n+T >= c.
    ref_hi    = {1'b0, ref_pix} + {1'b0, cfg.threshold};
    nb_plus_t = {1'b0, nb} + {1'b0, cfg.threshold};
    case (cfg.mode)
      lpc_pkg::MODE_LBP:    trit = {1'b0, nb > center};
      lpc_pkg::MODE_CS_LBP: trit = {1'b0, nb >= opp};
      default: begin
        if ({1'b0, nb} >= ref_hi) begin
          trit = 2'd2;
        end else if (nb_plus_t >= {1'b0, ref_pix}) begin
          trit = 2'd1;
        end else begin
          trit = 2'd0;
        end
      end
    endcase
  end

endmodule

// ===== hdl/lpc_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpc_merge
// Combines the eight lane results into one binary or ternary code.
// ----------------------------------------------------------------------------
module lpc_merge (
  input  lpc_pkg::trit_vec_t            trits,
  input  logic                          ternary,
  output logic [lpc_pkg::CODE_W-1:0]    code
);

  logic [lpc_pkg::CODE_W-1:0] terms [lpc_pkg::NB_COUNT];
  logic [lpc_pkg::CODE_W-1:0] sum_lo;
  logic [lpc_pkg::CODE_W-1:0] sum_hi;
  logic [lpc_pkg::NB_COUNT-1:0] bits;

  always_comb begin
    for (int k = 0; k < lpc_pkg::NB_COUNT; k++) begin
      bits[k]  = trits[k][0];
      terms[k] = trits[k][1] ? (lpc_pkg::POW3[k] << 1)
               : (trits[k][0] ? lpc_pkg::POW3[k] : '0);
    end
    sum_lo = (terms[0] + terms[1]) + (terms[2] + terms[3]);
    sum_hi = (terms[4] + terms[5]) + (terms[6] + terms[7]);
    code   = ternary ? (sum_lo + sum_hi)
                     : {{(lpc_pkg::CODE_W - lpc_pkg::NB_COUNT){1'b0}}, bits};
  end

endmodule
